>>> hdl/owb_pkg.sv
// ----------------------------------------------------------------------------
// owb_pkg
// Types, codes and helpers shared by the 1-Wire bus master files.
// ----------------------------------------------------------------------------
package owb_pkg;

    // phase codes
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_RST_LOW  = 4'd1;
    localparam logic [3:0] PH_RST_WAIT = 4'd2;
    localparam logic [3:0] PH_RST_REC  = 4'd3;
    localparam logic [3:0] PH_WR_LOW   = 4'd4;
    localparam logic [3:0] PH_WR_HOLD  = 4'd5;
    localparam logic [3:0] PH_WR_REL   = 4'd6;
    localparam logic [3:0] PH_RD_LOW   = 4'd7;
    localparam logic [3:0] PH_RD_WAIT  = 4'd8;
    localparam logic [3:0] PH_RD_REC   = 4'd9;
    localparam logic [3:0] PH_WAIT_HI  = 4'd10;

    // command codes
    localparam logic [2:0] FN_TICK    = 3'd0;
    localparam logic [2:0] FN_RESET   = 3'd1;
    localparam logic [2:0] FN_WRITE   = 3'd2;
    localparam logic [2:0] FN_READ    = 3'd3;
    localparam logic [2:0] FN_WAIT_HI = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PRES  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    // register indexes
    localparam logic [2:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [2:0] CFG_PRES_WINDOW  = 3'd1;
    localparam logic [2:0] CFG_PRES_REC     = 3'd2;
    localparam logic [2:0] CFG_WRITE_SLOT   = 3'd3;
    localparam logic [2:0] CFG_READ_SAMPLE  = 3'd4;
    localparam logic [2:0] CFG_READ_REC     = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int TIME_W     = 21;

    localparam logic [TIME_W-1:0] READ_LOW_TICKS = 21'd2;
    localparam logic [7:0]        CRC_POLY       = 8'h8C;

    typedef struct packed {
        logic [2:0]        func;
        logic [7:0]        data_byte;
        logic [TIME_W-1:0] wait_limit;
        logic              line_in;
    } t_in_word;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
        logic       crc_zero;
    } t_out_word;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_window;
        logic [9:0] presence_recovery;
        logic [7:0] write_slot_time;
        logic [5:0] read_sample_delay;
        logic [7:0] read_recovery_time;
    } t_cfg;

    typedef struct packed {
        logic [3:0]        phase;
        logic [TIME_W-1:0] time_left;
        logic [2:0]        bit_index;
        logic [7:0]        shift_byte;
        logic [7:0]        running_crc;
        logic [1:0]        last_status;
        logic [7:0]        last_read;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        reset_low_time:     10'd500,
        presence_window:    10'd480,
        presence_recovery:  10'd400,
        write_slot_time:    8'd60,
        read_sample_delay:  6'd8,
        read_recovery_time: 8'd65
    };

    // Dallas CRC-8, reflected, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hdl/onewire_bus_master_top.sv
// ----------------------------------------------------------------------------
// onewire_bus_master_top
// 1-Wire bus master stepped once per microsecond tick word.
//
//  channel  | direction | handshake                 | word
//  ---------+-----------+---------------------------+-------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_word (t_in_word)
//  out      | output    | o_out_valid / i_out_ready | o_out_word (t_out_word)
//  cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  One tick word per cycle sustained while the output is not stalled; a word's
//  result passes through the input register, then the result register.
//  The state update for a tick is one pass through owb_step.
//  Reset returns the state and config registers to defaults and empties both word registers.
//  A stalled output holds the pending input word and the bus state.
// ----------------------------------------------------------------------------
module onewire_bus_master_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  owb_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output owb_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [owb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic               r_in_valid;
    owb_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    owb_pkg::t_out_word r_out_word;
    owb_pkg::t_state    r_state;
    owb_pkg::t_cfg      r_cfg;

    owb_pkg::t_state    n_state;
    owb_pkg::t_out_word n_out_word;
    logic               w_adv;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    owb_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_word  (r_in_word),
        .o_state (n_state),
        .o_word  (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owb_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                owb_pkg::CFG_RESET_LOW:   r_cfg.reset_low_time     <= i_cfg_data;
                owb_pkg::CFG_PRES_WINDOW: r_cfg.presence_window    <= i_cfg_data;
                owb_pkg::CFG_PRES_REC:    r_cfg.presence_recovery  <= i_cfg_data;
                owb_pkg::CFG_WRITE_SLOT:  r_cfg.write_slot_time    <= i_cfg_data[7:0];
                owb_pkg::CFG_READ_SAMPLE: r_cfg.read_sample_delay  <= i_cfg_data[5:0];
                owb_pkg::CFG_READ_REC:    r_cfg.read_recovery_time <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_word.done_res && r_out_word.busy_res))
        else $error("done and busy both set");

    a_busy_tracks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_word.busy_res == (r_state.phase != owb_pkg::PH_IDLE)))
        else $error("busy does not match phase");

    a_crc_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out_word.crc_zero == (r_state.running_crc == '0)))
        else $error("crc flag does not match crc state");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_word.status != owb_pkg::ST_RESERVED))
        else $error("reserved status code");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_state))
        else $error("state moved during output stall");
`endif

endmodule

>>> hdl/owb_step.sv
// ----------------------------------------------------------------------------
// owb_step
// Next-state and result logic for one microsecond tick of the bus master.
// ----------------------------------------------------------------------------
module owb_step (
    input  owb_pkg::t_state    i_state,
    input  owb_pkg::t_cfg      i_cfg,
    input  owb_pkg::t_in_word  i_word,
    output owb_pkg::t_state    o_state,
    output owb_pkg::t_out_word o_word
);

    always_comb begin
        owb_pkg::t_state s;
        logic [owb_pkg::TIME_W-1:0] tl_dec;
        logic cd;
        logic drive;
        logic fin;
        logic [1:0] fin_st;
        logic rd_end;

        s      = i_state;
        drive  = 1'b0;
        fin    = 1'b0;
        fin_st = owb_pkg::ST_OK;
        rd_end = 1'b0;

        if (s.phase == owb_pkg::PH_IDLE) begin
            case (i_word.func)
                owb_pkg::FN_RESET: begin
                    s.bit_index   = '0;
                    s.running_crc = '0;
                    s.phase       = owb_pkg::PH_RST_LOW;
                    s.time_left   = (i_cfg.reset_low_time == '0) ? 21'd1
                                  : {11'd0, i_cfg.reset_low_time};
                end
                owb_pkg::FN_WRITE: begin
                    s.bit_index  = '0;
                    s.shift_byte = i_word.data_byte;
                    s.phase      = owb_pkg::PH_WR_LOW;
                    s.time_left  = 21'd1;
                end
                owb_pkg::FN_READ: begin
                    s.bit_index  = '0;
                    s.shift_byte = '0;
                    s.phase      = owb_pkg::PH_RD_LOW;
                    s.time_left  = owb_pkg::READ_LOW_TICKS;
                end
                owb_pkg::FN_WAIT_HI: begin
                    s.bit_index = '0;
                    s.phase     = owb_pkg::PH_WAIT_HI;
                    s.time_left = i_word.wait_limit;
                end
                default: begin
                end
            endcase
        end

        tl_dec = (s.time_left != '0) ? s.time_left - 21'd1 : s.time_left;
        cd     = (tl_dec == '0);

        case (s.phase)
            owb_pkg::PH_RST_LOW: begin
                drive       = 1'b1;
                s.time_left = tl_dec;
                if (cd) begin
                    s.phase     = owb_pkg::PH_RST_WAIT;
                    s.time_left = (i_cfg.presence_window == '0) ? 21'd1
                                : {11'd0, i_cfg.presence_window};
                end
            end
            owb_pkg::PH_RST_WAIT: begin
                if (s.time_left == '0) begin
                    fin    = 1'b1;
                    fin_st = owb_pkg::ST_NO_PRES;
                end else if (!i_word.line_in) begin
                    if (i_cfg.presence_recovery == '0) begin
                        fin = 1'b1;
                    end else begin
                        s.phase     = owb_pkg::PH_RST_REC;
                        s.time_left = {11'd0, i_cfg.presence_recovery};
                    end
                end else begin
                    s.time_left = tl_dec;
                    if (cd) begin
                        fin    = 1'b1;
                        fin_st = owb_pkg::ST_NO_PRES;
                    end
                end
            end
            owb_pkg::PH_RST_REC: begin
                s.time_left = tl_dec;
                fin         = cd;
            end
            owb_pkg::PH_WR_LOW: begin
                drive       = 1'b1;
                s.phase     = owb_pkg::PH_WR_HOLD;
                s.time_left = (i_cfg.write_slot_time == '0) ? 21'd1
                            : {13'd0, i_cfg.write_slot_time};
            end
            owb_pkg::PH_WR_HOLD: begin
                drive       = ~s.shift_byte[0];
                s.time_left = tl_dec;
                if (cd) begin
                    s.phase = owb_pkg::PH_WR_REL;
                end
            end
            owb_pkg::PH_WR_REL: begin
                s.shift_byte = s.shift_byte >> 1;
                if (s.bit_index == 3'd7) begin
                    fin = 1'b1;
                end else begin
                    s.bit_index = s.bit_index + 3'd1;
                    s.phase     = owb_pkg::PH_WR_LOW;
                    s.time_left = 21'd1;
                end
            end
            owb_pkg::PH_RD_LOW: begin
                drive       = 1'b1;
                s.time_left = tl_dec;
                if (cd) begin
                    s.phase     = owb_pkg::PH_RD_WAIT;
                    s.time_left = (i_cfg.read_sample_delay == '0) ? 21'd1
                                : {15'd0, i_cfg.read_sample_delay};
                end
            end
            owb_pkg::PH_RD_WAIT: begin
                s.time_left = tl_dec;
                if (cd) begin
                    s.shift_byte = {i_word.line_in, s.shift_byte[7:1]};
                    if (i_cfg.read_recovery_time == '0) begin
                        rd_end = 1'b1;
                    end else begin
                        s.phase     = owb_pkg::PH_RD_REC;
                        s.time_left = {13'd0, i_cfg.read_recovery_time};
                    end
                end
            end
            owb_pkg::PH_RD_REC: begin
                s.time_left = tl_dec;
                rd_end      = cd;
            end
            owb_pkg::PH_WAIT_HI: begin
                if (s.time_left == '0) begin
                    fin    = 1'b1;
                    fin_st = owb_pkg::ST_TIMEOUT;
                end else if (i_word.line_in) begin
                    fin = 1'b1;
                end else begin
                    s.time_left = tl_dec;
                    if (cd) begin
                        fin    = 1'b1;
                        fin_st = owb_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
                s.phase = owb_pkg::PH_IDLE;
            end
        endcase

        // end of one read slot
        if (rd_end) begin
            if (s.bit_index == 3'd7) begin
                s.last_read   = s.shift_byte;
                s.running_crc = owb_pkg::crc8_byte(s.running_crc, s.shift_byte);
                fin           = 1'b1;
            end else begin
                s.bit_index = s.bit_index + 3'd1;
                s.phase     = owb_pkg::PH_RD_LOW;
                s.time_left = owb_pkg::READ_LOW_TICKS;
            end
        end

        if (fin) begin
            s.phase       = owb_pkg::PH_IDLE;
            s.time_left   = '0;
            s.last_status = fin_st;
        end

        o_state            = s;
        o_word.drive_low   = drive;
        o_word.busy_res    = (s.phase != owb_pkg::PH_IDLE);
        o_word.done_res    = fin;
        o_word.status      = s.last_status;
        o_word.read_data   = s.last_read;
        o_word.crc_zero    = (s.running_crc == '0);
    end

endmodule
